/* rtl/nv21_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nv21_pkg
// shared constants and helpers for the nv21 to rgb pixel converter
// ----------------------------------------------------------------------------
package nv21_pkg;

   // largest frame or bitmap dimension
   localparam int MAX_DIM  = 4096;
   localparam int CNT_W    = $clog2(MAX_DIM);
   localparam int DIM_W    = CNT_W + 1;
   localparam int IDX_W    = 24;
   localparam int WORD_W   = 32;
   localparam int PIX_W    = 8;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_FORMAT = 3'd0,
      CSR_FRAME_WIDTH   = 3'd1,
      CSR_FRAME_HEIGHT  = 3'd2,
      CSR_BITMAP_WIDTH  = 3'd3,
      CSR_BITMAP_HEIGHT = 3'd4
   } csr_index_type;

   // output format codes, code 3 falls back to gray
   localparam logic [1:0] FMT_ABGR   = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_GRAY   = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = DIM_W'(640);
   localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = DIM_W'(480);
   localparam logic [DIM_W-1:0] RST_BITMAP_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RST_BITMAP_HEIGHT = DIM_W'(480);

   // bt.601 coefficients, 10-bit fraction
   localparam int signed K_Y      = 1192;
   localparam int signed K_R_CR   = 1634;
   localparam int signed K_G_CR   = 833;
   localparam int signed K_G_CB   = 400;
   localparam int signed K_B_CB   = 2066;
   localparam int        ABGR_MAX = 262143;

   // bt.601 coefficients, 8-bit fraction
   localparam int signed L_R_CR = 359;
   localparam int signed L_G_CB = 88;
   localparam int signed L_G_CR = 183;
   localparam int signed L_B_CB = 454;

   localparam int LUMA_OFFSET   = 16;
   localparam int CHROMA_OFFSET = 128;

   // clamp a write value into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] fit_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // clamp to 0..ABGR_MAX and keep the top 8 of 18 bits
   function automatic logic [7:0] abgr_chan(input logic signed [20:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 21'(ABGR_MAX)) begin
         r = 8'hFF;
      end else begin
         r = v[17:10];
      end
      return r;
   endfunction

   // clamp to 0..255
   function automatic logic [7:0] byte_chan(input logic signed [10:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 11'sd255) begin
         r = 8'hFF;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/nv21_to_rgb_pixel_converter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nv21_to_rgb_pixel_converter_unit
// converts one y/cr/cb pixel per request into an abgr, rgb565 or gray word
// and the element index that centers the frame inside a larger bitmap
// ----------------------------------------------------------------------------
//  - req channel: luma plus the cr/cb bytes of the pixel's 2x2 block, in
//    raster order; valid/ready, taken when both are high
//  - rsp channel: pixel word, bitmap index, last-of-frame and misfit flags
//  - csr port: one write per cycle when csr_write_enable is high; sizes are
//    clamped to 1..4096, writes to unknown indexes are dropped
//  - an input register and a result register: rsp_valid rises after a taken
//    request moves through both; one request per clock while rsp_ready is high
//  - the column/row counters and the write index live at the input stage,
//    the frame offset multiply happens there on the first pixel of a frame
//  - color math (constant multiplies, clamp, pack) sits between the registers
//  - a stalled receiver holds the result register; the input stage keeps
//    taking requests until both registers are full, then req_ready drops
//  - reset clears the pipeline, the counters and the csr registers
//    (format abgr, 640x480 frame, 640x480 bitmap)
// ----------------------------------------------------------------------------
module nv21_to_rgb_pixel_converter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [nv21_pkg::PIX_W-1:0]        req_luma,
   input  wire logic [nv21_pkg::PIX_W-1:0]        req_chroma_red,
   input  wire logic [nv21_pkg::PIX_W-1:0]        req_chroma_blue,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [nv21_pkg::WORD_W-1:0]            rsp_pixel_word,
   output logic [nv21_pkg::IDX_W-1:0]             rsp_pixel_index,
   output logic                                   rsp_last_of_frame,
   output logic                                   rsp_misfit,
   // csr write port
   input  wire logic                              csr_write_enable,
   input  wire logic [nv21_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [nv21_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DIM_W = nv21_pkg::DIM_W;
   localparam int CNT_W = nv21_pkg::CNT_W;
   localparam int IDX_W = nv21_pkg::IDX_W;
   localparam int PIX_W = nv21_pkg::PIX_W;

   // csr registers
   logic [1:0]        output_format_ff;
   logic [DIM_W-1:0]  frame_width_ff;
   logic [DIM_W-1:0]  frame_height_ff;
   logic [DIM_W-1:0]  bitmap_width_ff;
   logic [DIM_W-1:0]  bitmap_height_ff;
   logic [DIM_W-1:0]  csr_dim;

   // raster position state
   logic [CNT_W-1:0]  column_count_ff, column_count_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [IDX_W-1:0]  write_index_ff, write_index_in;

   // pipeline control
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_open;
   logic              s1_move;
   logic              req_fire;

   // input stage payload
   logic [PIX_W-1:0]  s1_luma_ff;
   logic [PIX_W-1:0]  s1_cr_ff;
   logic [PIX_W-1:0]  s1_cb_ff;
   logic [IDX_W-1:0]  s1_index_ff;
   logic              s1_last_ff;
   logic              s1_misfit_ff;

   // result register
   logic [nv21_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              rsp_last_ff;
   logic              rsp_misfit_ff;

   // index math
   logic signed [DIM_W:0]    dv_diff, dh_diff;
   logic signed [DIM_W-1:0]  dv_half, dh_half;
   logic signed [IDX_W-1:0]  offset_prod;
   logic [IDX_W-1:0]         frame_offset;
   logic [IDX_W-1:0]         cur_index;
   logic                     first_pixel;
   logic                     col_wrap, row_wrap;
   logic                     misfit;
   logic                     cur_last;

   // color math
   logic [PIX_W-1:0]         y_lum;
   logic signed [20:0]       y21, cr21, cb21;
   logic signed [20:0]       r_full, g_full, b_full;
   logic signed [17:0]       cr18, cb18;
   logic signed [17:0]       r_prod, g_prod, b_prod;
   logic signed [10:0]       y11;
   logic signed [10:0]       r_sum, g_sum, b_sum;
   logic [7:0]               r565, g565, b565;

   // ---------------------------------------------------------------- csr
   assign csr_dim = nv21_pkg::fit_dim(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         output_format_ff <= nv21_pkg::FMT_ABGR;
         frame_width_ff   <= nv21_pkg::RST_FRAME_WIDTH;
         frame_height_ff  <= nv21_pkg::RST_FRAME_HEIGHT;
         bitmap_width_ff  <= nv21_pkg::RST_BITMAP_WIDTH;
         bitmap_height_ff <= nv21_pkg::RST_BITMAP_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            nv21_pkg::CSR_OUTPUT_FORMAT: output_format_ff <= csr_wdata[1:0];
            nv21_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_dim;
            nv21_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_dim;
            nv21_pkg::CSR_BITMAP_WIDTH:  bitmap_width_ff  <= csr_dim;
            nv21_pkg::CSR_BITMAP_HEIGHT: bitmap_height_ff <= csr_dim;
            default: ;  // unknown index, dropped
         endcase
      end
   end

   // ----------------------------------------------------------- handshake
   // result register frees up when empty or being drained this cycle
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_open;
   assign req_ready = !s1_valid_ff || out_open;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   // --------------------------------------------------------- index logic
   // centering offset, floor of half the size difference on each axis
   assign dv_diff  = $signed({1'b0, bitmap_height_ff}) - $signed({1'b0, frame_height_ff});
   assign dh_diff  = $signed({1'b0, bitmap_width_ff}) - $signed({1'b0, frame_width_ff});
   assign dv_half  = DIM_W'(dv_diff >>> 1);
   assign dh_half  = DIM_W'(dh_diff >>> 1);
   assign offset_prod  = IDX_W'(dv_half) * $signed(IDX_W'({1'b0, bitmap_width_ff}));
   assign frame_offset = IDX_W'(offset_prod) + IDX_W'(dh_half);

   assign first_pixel = (column_count_ff == '0) && (row_count_ff == '0);
   assign cur_index   = first_pixel ? frame_offset : write_index_ff;

   // a count already past a shrunken size also ends the row or frame
   assign col_wrap = !((DIM_W'(column_count_ff) + DIM_W'(1)) < frame_width_ff);
   assign row_wrap = !((DIM_W'(row_count_ff) + DIM_W'(1)) < frame_height_ff);
   assign cur_last = col_wrap && row_wrap;

   assign misfit = (bitmap_width_ff < frame_width_ff) || (bitmap_height_ff < frame_height_ff);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      write_index_in  = write_index_ff;
      if (req_fire) begin
         if (!col_wrap) begin
            column_count_in = column_count_ff + CNT_W'(1);
            write_index_in  = cur_index + IDX_W'(1);
         end else begin
            column_count_in = '0;
            // skip the bitmap margin to the next row
            write_index_in  = cur_index + IDX_W'(1) + IDX_W'(bitmap_width_ff)
                              - IDX_W'(frame_width_ff);
            row_count_in    = row_wrap ? '0 : row_count_ff + CNT_W'(1);
         end
      end
   end

   // --------------------------------------------------------- color logic
   // luma below the black level counts as black
   assign y_lum = (s1_luma_ff < PIX_W'(nv21_pkg::LUMA_OFFSET)) ? '0
                  : s1_luma_ff - PIX_W'(nv21_pkg::LUMA_OFFSET);

   assign y21  = $signed(21'(y_lum));
   assign cr21 = $signed(21'(s1_cr_ff)) - 21'(nv21_pkg::CHROMA_OFFSET);
   assign cb21 = $signed(21'(s1_cb_ff)) - 21'(nv21_pkg::CHROMA_OFFSET);

   // abgr path, 10-bit fraction
   assign r_full = 21'(nv21_pkg::K_Y) * y21 + 21'(nv21_pkg::K_R_CR) * cr21;
   assign g_full = 21'(nv21_pkg::K_Y) * y21 - 21'(nv21_pkg::K_G_CR) * cr21
                   - 21'(nv21_pkg::K_G_CB) * cb21;
   assign b_full = 21'(nv21_pkg::K_Y) * y21 + 21'(nv21_pkg::K_B_CB) * cb21;

   // rgb565 path, 8-bit fraction with floor shifts
   assign cr18   = 18'(cr21);
   assign cb18   = 18'(cb21);
   assign r_prod = 18'(nv21_pkg::L_R_CR) * cr18;
   assign g_prod = 18'(nv21_pkg::L_G_CB) * cb18 + 18'(nv21_pkg::L_G_CR) * cr18;
   assign b_prod = 18'(nv21_pkg::L_B_CB) * cb18;

   assign y11   = $signed(11'(y_lum));
   assign r_sum = y11 + 11'(r_prod >>> 8);
   assign g_sum = y11 - 11'(g_prod >>> 8);
   assign b_sum = y11 + 11'(b_prod >>> 8);

   assign r565 = nv21_pkg::byte_chan(r_sum);
   assign g565 = nv21_pkg::byte_chan(g_sum);
   assign b565 = nv21_pkg::byte_chan(b_sum);

   always_comb begin
      case (output_format_ff)
         nv21_pkg::FMT_ABGR:
            rsp_word_in = {8'hFF, nv21_pkg::abgr_chan(b_full),
                           nv21_pkg::abgr_chan(g_full), nv21_pkg::abgr_chan(r_full)};
         nv21_pkg::FMT_RGB565:
            rsp_word_in = {16'd0, r565[7:3], g565[7:2], b565[7:3]};
         default:
            // gray, also the unused code
            rsp_word_in = {24'd0, s1_luma_ff};
      endcase
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         write_index_ff  <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         write_index_ff  <= write_index_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_luma_ff   <= req_luma;
         s1_cr_ff     <= req_chroma_red;
         s1_cb_ff     <= req_chroma_blue;
         s1_index_ff  <= misfit ? '0 : cur_index;
         s1_last_ff   <= cur_last;
         s1_misfit_ff <= misfit;
      end
      if (s1_move) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_index_ff  <= s1_index_ff;
         rsp_last_ff   <= s1_last_ff;
         rsp_misfit_ff <= s1_misfit_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_word    = rsp_word_ff;
   assign rsp_pixel_index   = rsp_index_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign rsp_misfit        = rsp_misfit_ff;

endmodule
`default_nettype wire
